### rtl/sdbq_pkg.sv
// Shared types and constants for the spectrum dB baseline quantizer.
// No dependencies; every other file refers to it by scoped names.
package sdbq_pkg;

   localparam int CH_W    = 10;
   localparam int POW_W   = 32;
   localparam int BASE_W  = 24;
   localparam int SLOT_W  = 9;
   localparam int LEVEL_W = 16;
   localparam int GAIN_W  = 16;
   localparam int X_W     = 33;
   localparam int EXP_W   = 6;
   localparam int FRAC_W  = 24;
   localparam int LOG_W   = EXP_W + FRAC_W;
   localparam int D_W     = 26;
   localparam int PROD_W  = D_W + GAIN_W + 1;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_FIRST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_LAST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_FIRST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_LAST   = 3'd4;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET        = 16'd1000;
   localparam logic [CH_W-1:0]   RIGHT_FIRST_RESET = 10'd103;
   localparam logic [CH_W-1:0]   RIGHT_LAST_RESET  = 10'd512;
   localparam logic [CH_W-1:0]   LEFT_FIRST_RESET  = 10'd564;
   localparam logic [CH_W-1:0]   LEFT_LAST_RESET   = 10'd973;

   // 10*log10(2) in Q32, split into two 17 bit halves for the multipliers
   localparam logic [33:0] TEN_LOG2_Q32 = 34'd12929139865;
   localparam int K_SPLIT = 17;

   localparam logic signed [D_W-1:0] DB_OFFSET_Q16 = -26'sd6309806;
   localparam logic signed [D_W-1:0] DB_FLOOR_Q16  = -26'sd6553600;
   localparam logic signed [D_W-1:0] MARGIN_Q16    = 26'sd196608;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [CH_W-1:0]   right_first;
      logic [CH_W-1:0]   right_last;
      logic [CH_W-1:0]   left_first;
      logic [CH_W-1:0]   left_last;
   } cfg_type;

   typedef struct packed {
      logic                     side;
      logic [SLOT_W-1:0]        slot;
      logic                     zero;
      logic signed [BASE_W-1:0] base;
   } tag_type;

endpackage

### rtl/spectrum_db_baseline_quantizer.sv
// Top level of the spectrum dB baseline quantizer: registers, pipeline, output buffer.
// Depends on sdbq_pkg, sdbq_front, sdbq_log2 and sdbq_scale.
//
// Takes one item per clock while req_tready is high and returns at most one result
// per sample, in order, through the front end, the 24 stage squaring log2 pipeline,
// dB scaling and the output register. A load item (tuser 0) writes one baseline into
// a min(CHANNELS, 1024) entry memory with one write and one registered read port;
// reading a baseline that was never loaded gives an undefined level. Samples
// outside both windows and loads give no result. An output register with one
// skid entry keeps req_tready registered, so the pipeline stalls only when the
// downstream side holds off for two results.
// Write configuration only while no item is in flight.
module spectrum_db_baseline_quantizer #(
   parameter int CHANNELS   = 1024,
   parameter int WINDOW_LEN = 410
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sdbq_pkg::REQ_DATA_W-1:0]      req_tdata,  // channel, power, baseline, zero pad
   input  logic                                 req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sdbq_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // slot, level, zero pad
   output logic                                 rsp_tuser,  // side
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sdbq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sdbq_pkg::CSR_DATA_W-1:0]      csr_data
);

   sdbq_pkg::cfg_type                  cfg_ff;
   logic                               adv;
   logic                               accept;
   logic                               front_valid;
   sdbq_pkg::tag_type                  front_tag;
   logic [sdbq_pkg::X_W-1:0]           front_x;
   logic                               log_valid;
   sdbq_pkg::tag_type                  log_tag;
   logic [sdbq_pkg::LOG_W-1:0]         log_val;
   logic                               fin_valid;
   logic                               fin_side;
   logic [sdbq_pkg::SLOT_W-1:0]        fin_slot;
   logic [sdbq_pkg::LEVEL_W-1:0]       fin_level;
   logic                               fin_xfer;
   logic                               take;

   logic                               rsp_valid_ff;
   logic                               rsp_side_ff;
   logic [sdbq_pkg::SLOT_W-1:0]        rsp_slot_ff;
   logic [sdbq_pkg::LEVEL_W-1:0]       rsp_level_ff;
   logic                               skid_full_ff;
   logic                               skid_side_ff;
   logic [sdbq_pkg::SLOT_W-1:0]        skid_slot_ff;
   logic [sdbq_pkg::LEVEL_W-1:0]       skid_level_ff;

   assign csr_ready  = 1'b1;
   assign adv        = !skid_full_ff;
   assign req_tready = adv;
   assign accept     = req_tvalid && req_tready;
   assign fin_xfer   = fin_valid && adv;
   assign take       = rsp_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain        <= sdbq_pkg::GAIN_RESET;
         cfg_ff.right_first <= sdbq_pkg::RIGHT_FIRST_RESET;
         cfg_ff.right_last  <= sdbq_pkg::RIGHT_LAST_RESET;
         cfg_ff.left_first  <= sdbq_pkg::LEFT_FIRST_RESET;
         cfg_ff.left_last   <= sdbq_pkg::LEFT_LAST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sdbq_pkg::CSR_GAIN:        cfg_ff.gain        <= csr_data;
            sdbq_pkg::CSR_RIGHT_FIRST: cfg_ff.right_first <= csr_data[sdbq_pkg::CH_W-1:0];
            sdbq_pkg::CSR_RIGHT_LAST:  cfg_ff.right_last  <= csr_data[sdbq_pkg::CH_W-1:0];
            sdbq_pkg::CSR_LEFT_FIRST:  cfg_ff.left_first  <= csr_data[sdbq_pkg::CH_W-1:0];
            sdbq_pkg::CSR_LEFT_LAST:   cfg_ff.left_last   <= csr_data[sdbq_pkg::CH_W-1:0];
            default: ;
         endcase
      end
   end

   sdbq_front #(
      .CHANNELS   (CHANNELS),
      .WINDOW_LEN (WINDOW_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .accept    (accept),
      .kind      (req_tuser),
      .channel   (req_tdata[9:0]),
      .power     (req_tdata[41:10]),
      .baseline  ($signed(req_tdata[65:42])),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_tag   (front_tag),
      .out_x     (front_x)
   );

   sdbq_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_tag    (front_tag),
      .in_x      (front_x),
      .out_valid (log_valid),
      .out_tag   (log_tag),
      .out_log   (log_val)
   );

   sdbq_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (log_valid),
      .in_tag    (log_tag),
      .in_log    (log_val),
      .gain      (cfg_ff.gain),
      .out_valid (fin_valid),
      .out_side  (fin_side),
      .out_slot  (fin_slot),
      .out_level (fin_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (!rsp_valid_ff || take) begin
         if (skid_full_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= fin_xfer;
         end
      end else if (fin_xfer) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || take) begin
         if (skid_full_ff) begin
            rsp_side_ff  <= skid_side_ff;
            rsp_slot_ff  <= skid_slot_ff;
            rsp_level_ff <= skid_level_ff;
         end else begin
            rsp_side_ff  <= fin_side;
            rsp_slot_ff  <= fin_slot;
            rsp_level_ff <= fin_level;
         end
      end else if (fin_xfer) begin
         skid_side_ff  <= fin_side;
         skid_slot_ff  <= fin_slot;
         skid_level_ff <= fin_level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_side_ff;
   assign rsp_tdata  = {7'd0, rsp_level_ff, rsp_slot_ff};

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending output");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && !rsp_tready))
      else $error("skid filled while the output register was free");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !rsp_tready |=> skid_full_ff)
      else $error("skid entry dropped without an output transfer");

   a_stall_no_advance: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && fin_valid |=> fin_valid)
      else $error("pipeline result lost during stall");
`endif

endmodule

### rtl/sdbq_front.sv
// Front end: baseline memory, window match and log argument setup.
// Depends on sdbq_pkg.
module sdbq_front #(
   parameter int CHANNELS   = 1024,
   parameter int WINDOW_LEN = 410
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               accept,
   input  logic                               kind,
   input  logic [sdbq_pkg::CH_W-1:0]          channel,
   input  logic [sdbq_pkg::POW_W-1:0]         power,
   input  logic signed [sdbq_pkg::BASE_W-1:0] baseline,
   input  sdbq_pkg::cfg_type                  cfg,
   output logic                               out_valid,
   output sdbq_pkg::tag_type                  out_tag,
   output logic [sdbq_pkg::X_W-1:0]           out_x
);

   localparam int DEPTH = (CHANNELS < 1024) ? CHANNELS : 1024;
   localparam int AW    = $clog2(DEPTH);

   logic signed [sdbq_pkg::BASE_W-1:0] mem [DEPTH];

   logic                               in_range;
   logic                               s1_valid_ff;
   logic [sdbq_pkg::CH_W-1:0]          s1_ch_ff;
   logic [sdbq_pkg::POW_W-1:0]         s1_power_ff;
   logic                               s1_range_ff;
   logic signed [sdbq_pkg::BASE_W-1:0] base_rd_ff;

   logic                               r_hit;
   logic                               l_hit;
   logic [sdbq_pkg::CH_W-1:0]          r_diff;
   logic [sdbq_pkg::CH_W-1:0]          l_diff;
   logic                               s2_valid_in;
   sdbq_pkg::tag_type                  s2_tag_in;
   logic                               s2_valid_ff;
   sdbq_pkg::tag_type                  s2_tag_ff;
   logic [sdbq_pkg::X_W-1:0]           s2_x_ff;

   assign in_range = 32'(channel) < 32'(CHANNELS);

   always_ff @(posedge clock) begin
      if (accept && kind == sdbq_pkg::KIND_LOAD && in_range) begin
         mem[channel[AW-1:0]] <= baseline;
      end
      if (adv && in_range) begin
         base_rd_ff <= mem[channel[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept && kind == sdbq_pkg::KIND_SAMPLE;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ch_ff    <= channel;
         s1_power_ff <= power;
         s1_range_ff <= in_range;
         s2_tag_ff   <= s2_tag_in;
         s2_x_ff     <= {1'b0, s1_power_ff} + 33'd1;
      end
   end

   always_comb begin
      r_diff = s1_ch_ff - cfg.right_first;
      l_diff = cfg.left_last - s1_ch_ff;
      r_hit  = s1_ch_ff >= cfg.right_first && s1_ch_ff <= cfg.right_last &&
               32'(r_diff) < 32'(WINDOW_LEN);
      l_hit  = s1_ch_ff >= cfg.left_first && s1_ch_ff <= cfg.left_last &&
               32'(l_diff) < 32'(WINDOW_LEN);
      s2_valid_in    = s1_valid_ff && (r_hit || l_hit);
      s2_tag_in.side = !r_hit;
      s2_tag_in.slot = r_hit ? r_diff[sdbq_pkg::SLOT_W-1:0] : l_diff[sdbq_pkg::SLOT_W-1:0];
      s2_tag_in.zero = s1_power_ff == '0;
      s2_tag_in.base = s1_range_ff ? base_rd_ff : '0;
   end

   assign out_valid = s2_valid_ff;
   assign out_tag   = s2_tag_ff;
   assign out_x     = s2_x_ff;

endmodule

### rtl/sdbq_log2.sv
// Pipelined log2: two normalizing stages, then one squaring stage per fraction bit.
// Depends on sdbq_pkg.
module sdbq_log2 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  sdbq_pkg::tag_type                in_tag,
   input  logic [sdbq_pkg::X_W-1:0]         in_x,
   output logic                             out_valid,
   output sdbq_pkg::tag_type                out_tag,
   output logic [sdbq_pkg::LOG_W-1:0]       out_log
);

   localparam int STEPS = sdbq_pkg::FRAC_W;

   logic [sdbq_pkg::X_W-1:0]   t0, t1, t2, u0, u1, u2;
   logic [2:0]                 lz_hi, lz_lo;
   logic                       n1_valid_ff;
   sdbq_pkg::tag_type          n1_tag_ff;
   logic [sdbq_pkg::X_W-1:0]   n1_x_ff;
   logic [2:0]                 n1_lz_ff;

   logic                        sq_valid_ff [STEPS+1];
   sdbq_pkg::tag_type           sq_tag_ff   [STEPS+1];
   logic [31:0]                 sq_y_ff     [STEPS+1];
   logic [sdbq_pkg::FRAC_W-1:0] sq_frac_ff  [STEPS+1];
   logic [sdbq_pkg::EXP_W-1:0]  sq_e_ff     [STEPS+1];

   always_comb begin
      lz_hi[2] = in_x[32:1] == '0;
      t0       = lz_hi[2] ? in_x << 32 : in_x;
      lz_hi[1] = t0[32:17] == '0;
      t1       = lz_hi[1] ? t0 << 16 : t0;
      lz_hi[0] = t1[32:25] == '0;
      t2       = lz_hi[0] ? t1 << 8 : t1;
      lz_lo[2] = n1_x_ff[32:29] == '0;
      u0       = lz_lo[2] ? n1_x_ff << 4 : n1_x_ff;
      lz_lo[1] = u0[32:31] == '0;
      u1       = lz_lo[1] ? u0 << 2 : u0;
      lz_lo[0] = !u1[32];
      u2       = lz_lo[0] ? u1 << 1 : u1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff    <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         n1_valid_ff    <= in_valid;
         sq_valid_ff[0] <= n1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_tag_ff     <= in_tag;
         n1_x_ff       <= t2;
         n1_lz_ff      <= lz_hi;
         sq_tag_ff[0]  <= n1_tag_ff;
         sq_y_ff[0]    <= u2[32:1];
         sq_frac_ff[0] <= '0;
         sq_e_ff[0]    <= 6'd32 - {n1_lz_ff, lz_lo};
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      logic [31:0] y_in;

      always_comb begin
         sq   = 64'(sq_y_ff[k]) * 64'(sq_y_ff[k]);
         t    = sq[63:31];
         y_in = t[32] ? t[32:1] : t[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_tag_ff[k+1]  <= sq_tag_ff[k];
            sq_y_ff[k+1]    <= y_in;
            sq_frac_ff[k+1] <= {sq_frac_ff[k][sdbq_pkg::FRAC_W-2:0], t[32]};
            sq_e_ff[k+1]    <= sq_e_ff[k];
         end
      end
   end

   assign out_valid = sq_valid_ff[STEPS];
   assign out_tag   = sq_tag_ff[STEPS];
   assign out_log   = {sq_e_ff[STEPS], sq_frac_ff[STEPS]};

endmodule

### rtl/sdbq_scale.sv
// dB conversion, baseline subtraction, gain multiply and saturation.
// Depends on sdbq_pkg.
module sdbq_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  sdbq_pkg::tag_type                 in_tag,
   input  logic [sdbq_pkg::LOG_W-1:0]        in_log,
   input  logic [sdbq_pkg::GAIN_W-1:0]       gain,
   output logic                              out_valid,
   output logic                              out_side,
   output logic [sdbq_pkg::SLOT_W-1:0]       out_slot,
   output logic [sdbq_pkg::LEVEL_W-1:0]      out_level
);

   localparam int PP_W = sdbq_pkg::LOG_W + sdbq_pkg::K_SPLIT;

   logic [sdbq_pkg::K_SPLIT-1:0] k_hi, k_lo;

   logic                                m1_valid_ff, m2_valid_ff, m3_valid_ff, m4_valid_ff;
   sdbq_pkg::tag_type                   m1_tag_ff, m2_tag_ff, m3_tag_ff, m4_tag_ff;
   logic [PP_W-1:0]                     m1_hi_ff, m1_lo_ff;
   logic [63:0]                         sum;
   logic [23:0]                         m2_scaled_ff;
   logic signed [sdbq_pkg::D_W-1:0]     db, d_in;
   logic signed [sdbq_pkg::D_W-1:0]     m3_d_ff;
   logic signed [sdbq_pkg::PROD_W-1:0]  m4_prod_ff;
   logic [sdbq_pkg::LEVEL_W-1:0]        level_in;
   logic                                m5_valid_ff;
   logic                                m5_side_ff;
   logic [sdbq_pkg::SLOT_W-1:0]         m5_slot_ff;
   logic [sdbq_pkg::LEVEL_W-1:0]        m5_level_ff;

   assign k_hi = sdbq_pkg::TEN_LOG2_Q32[33:17];
   assign k_lo = sdbq_pkg::TEN_LOG2_Q32[16:0];

   always_comb begin
      sum = {m1_hi_ff, 17'd0} + 64'(m1_lo_ff);
      db  = m2_tag_ff.zero ? sdbq_pkg::DB_FLOOR_Q16
                           : sdbq_pkg::DB_OFFSET_Q16 + $signed({2'b00, m2_scaled_ff});
      d_in = db - {{2{m2_tag_ff.base[23]}}, m2_tag_ff.base} + sdbq_pkg::MARGIN_Q16;
      if (m4_prod_ff <= 0) begin
         level_in = '0;
      end else if (m4_prod_ff[41:32] != '0) begin
         level_in = sdbq_pkg::LEVEL_MAX;
      end else begin
         level_in = m4_prod_ff[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
         m5_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
         m5_valid_ff <= m4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_tag_ff    <= in_tag;
         m1_hi_ff     <= PP_W'(in_log) * PP_W'(k_hi);
         m1_lo_ff     <= PP_W'(in_log) * PP_W'(k_lo);
         m2_tag_ff    <= m1_tag_ff;
         m2_scaled_ff <= sum[63:40];
         m3_tag_ff    <= m2_tag_ff;
         m3_d_ff      <= d_in;
         m4_tag_ff    <= m3_tag_ff;
         m4_prod_ff   <= $signed({1'b0, gain}) * m3_d_ff;
         m5_side_ff   <= m4_tag_ff.side;
         m5_slot_ff   <= m4_tag_ff.slot;
         m5_level_ff  <= level_in;
      end
   end

   assign out_valid = m5_valid_ff;
   assign out_side  = m5_side_ff;
   assign out_slot  = m5_slot_ff;
   assign out_level = m5_level_ff;

endmodule

### tb/spectrum_db_baseline_quantizer_tb.sv
// Self-checking testbench for spectrum_db_baseline_quantizer: baseline loads and power
// samples under random stalls, with the dB level computed independently in fixed point.
// Depends on sdbq_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module spectrum_db_baseline_quantizer_tb;

   localparam int  NUM_CHANNELS   = 1024;
   localparam int  SLOT_COUNT     = 410;
   localparam int  HOLD_CYCLES    = 300;
   localparam int  DRAIN_CYCLES   = 45;
   localparam int  CYCLE_LIMIT    = 800000;

   localparam longint DB_OFFSET   = -64'sd6309806;
   localparam longint DB_SILENCE  = -64'sd6553600;
   localparam longint HEADROOM    = 64'sd196608;
   localparam longint TEN_LOG2    = 64'sd12929139865;
   localparam longint LEVEL_TOP   = 64'sd65535;

   typedef struct packed {
      logic        side;
      logic [8:0]  slot;
      logic [15:0] level;
   } level_word;

   class quantizer_model;
      logic [15:0]        gain;
      logic [9:0]         right_first;
      logic [9:0]         right_last;
      logic [9:0]         left_first;
      logic [9:0]         left_last;
      logic signed [23:0] baseline_mem [NUM_CHANNELS];
      level_word          pending_levels [$];
      int                 mismatches;
      int                 checked;

      function new();
         gain        = 16'd1000;
         right_first = 10'd103;
         right_last  = 10'd512;
         left_first  = 10'd564;
         left_last   = 10'd973;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void set_reg(logic [sdbq_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
         case (idx)
            sdbq_pkg::CSR_GAIN:        gain        = value;
            sdbq_pkg::CSR_RIGHT_FIRST: right_first = value[9:0];
            sdbq_pkg::CSR_RIGHT_LAST:  right_last  = value[9:0];
            sdbq_pkg::CSR_LEFT_FIRST:  left_first  = value[9:0];
            sdbq_pkg::CSR_LEFT_LAST:   left_last   = value[9:0];
            default: ;
         endcase
      endfunction

      // dB in Q16 via a squaring log2 with 24 fraction bits
      function longint power_db_q16(logic [31:0] pwr);
         logic [32:0] x;
         logic [63:0] y;
         logic [63:0] lg;
         int          e;
         int          i;
         if (pwr == 32'd0) return DB_SILENCE;
         x = {1'b0, pwr} + 33'd1;
         e = 0;
         for (i = 0; i < 33; i++) if (x[i]) e = i;
         if (e >= 31) y = 64'(x) >> (e - 31);
         else y = 64'(x) << (31 - e);
         lg = 64'd0;
         for (i = 0; i < 24; i++) begin
            y  = (y * y) >> 31;
            lg = lg << 1;
            if (y >= 64'h1_0000_0000) begin
               lg[0] = 1'b1;
               y     = y >> 1;
            end
         end
         lg = lg | (64'(e) << 24);
         return DB_OFFSET + longint'((lg * 64'(TEN_LOG2)) >> 40);
      endfunction

      function void note_item(logic kind, logic [9:0] ch, logic [31:0] pwr,
                              logic signed [23:0] base);
         level_word w;
         bit        hit;
         longint    d;
         longint    prod;
         hit = 1'b0;
         if (kind == sdbq_pkg::KIND_LOAD) begin
            baseline_mem[ch] = base;
            return;
         end
         if (ch >= right_first && ch <= right_last
             && int'(ch) - int'(right_first) < SLOT_COUNT) begin
            w.side = 1'b0;
            w.slot = 9'(int'(ch) - int'(right_first));
            hit    = 1'b1;
         end else if (ch >= left_first && ch <= left_last
                      && int'(left_last) - int'(ch) < SLOT_COUNT) begin
            w.side = 1'b1;
            w.slot = 9'(int'(left_last) - int'(ch));
            hit    = 1'b1;
         end
         if (!hit) return;
         d    = power_db_q16(pwr) - longint'(baseline_mem[ch]) + HEADROOM;
         prod = longint'(gain) * d;
         if (prod <= 0) w.level = 16'd0;
         else if ((prod >>> 16) > LEVEL_TOP) w.level = 16'hFFFF;
         else w.level = 16'(prod >>> 16);
         pending_levels.push_back(w);
      endfunction

      task report(input string msg);
         mismatches++;
         if (mismatches <= 40) $display("mismatch: %s", msg);
      endtask

      task check_level(input logic side, input logic [8:0] slot, input logic [15:0] level);
         level_word want;
         checked++;
         if (pending_levels.size() == 0) begin
            report($sformatf("unexpected result side %0d slot %0d level %0d",
                             side, slot, level));
            return;
         end
         want = pending_levels.pop_front();
         if (side !== want.side || slot !== want.slot || level !== want.level)
            report($sformatf("side %0d/%0d slot %0d/%0d level %0d/%0d (got/want)",
                             side, want.side, slot, want.slot, level, want.level));
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [sdbq_pkg::REQ_DATA_W-1:0]     req_tdata;   // channel, power, baseline, zero pad
   logic                                req_tuser;   // kind
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [sdbq_pkg::RSP_DATA_W-1:0]     rsp_tdata;   // slot, level, zero pad
   logic                                rsp_tuser;   // side
   logic                                csr_valid;
   logic                                csr_ready;
   logic [sdbq_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [sdbq_pkg::CSR_DATA_W-1:0]     csr_data;

   quantizer_model sb = new();
   bit             loaded [NUM_CHANNELS];
   bit             calm;
   bit             hold_request;
   int             cycle_count;
   int             n_loads;
   int             n_samples;
   int             n_settings;

   spectrum_db_baseline_quantizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[spectrum_db_baseline_quantizer] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_level(rsp_tuser, rsp_tdata[8:0], rsp_tdata[24:9]);
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // receiver: random stalls, or a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   function automatic logic [9:0] pick_channel();
      int r;
      int edge_pick;
      r = $urandom_range(0, 9);
      if (r <= 3) return 10'($urandom_range(sb.right_first, sb.right_last));
      if (r <= 6) return 10'($urandom_range(sb.left_first, sb.left_last));
      if (r == 7) begin
         edge_pick = $urandom_range(0, 11);
         case (edge_pick)
            0:  return sb.right_first;
            1:  return sb.right_last;
            2:  return sb.left_first;
            3:  return sb.left_last;
            4:  return sb.right_first - 10'd1;
            5:  return sb.right_last + 10'd1;
            6:  return sb.left_first - 10'd1;
            7:  return sb.left_last + 10'd1;
            8:  return sb.right_first + 10'd409;
            9:  return sb.right_first + 10'd410;
            10: return sb.left_last - 10'd409;
            default: return sb.left_last - 10'd410;
         endcase
      end
      return 10'($urandom_range(0, NUM_CHANNELS - 1));
   endfunction

   function automatic logic signed [23:0] pick_baseline();
      if ($urandom_range(0, 9) < 6)
         return -24'(($urandom_range(40, 100) << 16) + $urandom_range(0, 65535));
      return 24'($urandom());
   endfunction

   function automatic logic [31:0] pick_power();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'($urandom_range(1, 255));
         3, 4, 5: return $urandom() >> $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [9:0] ch, input logic [31:0] pwr,
                            input logic signed [23:0] base);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, base, pwr, ch};
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, ch, pwr, base);
      if (kind == sdbq_pkg::KIND_LOAD) begin
         loaded[ch] = 1'b1;
         n_loads++;
      end else begin
         n_samples++;
      end
   endtask

   // never sample a channel whose baseline was not written
   task automatic send_sample(input logic [9:0] ch, input logic [31:0] pwr);
      if (!loaded[ch]) send_item(sdbq_pkg::KIND_LOAD, ch, $urandom(), pick_baseline());
      send_item(sdbq_pkg::KIND_SAMPLE, ch, pwr, 24'($urandom()));
   endtask

   task automatic after_item();
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sdbq_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
   endtask

   task automatic apply_config(input logic [15:0] g, input logic [9:0] rf, input logic [9:0] rl,
                               input logic [9:0] lf, input logic [9:0] ll);
      write_reg(sdbq_pkg::CSR_GAIN, g);
      write_reg(sdbq_pkg::CSR_RIGHT_FIRST, 16'(rf));
      write_reg(sdbq_pkg::CSR_RIGHT_LAST, 16'(rl));
      write_reg(sdbq_pkg::CSR_LEFT_FIRST, 16'(lf));
      write_reg(sdbq_pkg::CSR_LEFT_LAST, 16'(ll));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // count every transfer, including the loads that precede first samples
   task automatic random_phase(input int count);
      int k;
      int stop;
      stop = n_loads + n_samples + count;
      k    = 0;
      while (n_loads + n_samples < stop) begin
         if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 35)
            send_item(sdbq_pkg::KIND_LOAD, pick_channel(), $urandom(), pick_baseline());
         else
            send_sample(pick_channel(), pick_power());
         after_item();
         k++;
      end
      calm = 1'b0;
   endtask

   // receiver holds off while samples keep coming, so the input side must stall
   task automatic hold_burst(input int count);
      int k;
      hold_request = 1'b1;
      calm         = 1'b1;
      for (k = 0; k < count; k++) send_sample(pick_channel(), pick_power());
      calm = 1'b0;
   endtask

   task automatic directed_items();
      send_item(sdbq_pkg::KIND_LOAD, 10'd103, 32'd0, 24'sd0);
      send_item(sdbq_pkg::KIND_LOAD, 10'd512, 32'hFFFF_FFFF, 24'sh7FFFFF);
      send_item(sdbq_pkg::KIND_LOAD, 10'd564, 32'd0, 24'sh800000);
      send_item(sdbq_pkg::KIND_LOAD, 10'd973, 32'd7, -24'sd5898240);
      send_item(sdbq_pkg::KIND_LOAD, 10'd0, 32'd0, -24'sd6553600);
      send_item(sdbq_pkg::KIND_LOAD, 10'd1023, 32'd0, 24'shFFFFFF);
      send_item(sdbq_pkg::KIND_LOAD, 10'd540, 32'd0, -24'sd3276800);
      send_item(sdbq_pkg::KIND_LOAD, 10'd300, 32'd0, 24'sh400000);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd103, 32'd0, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd103, 32'd1, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd512, 32'hFFFF_FFFF, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd564, 32'hFFFF_FFFF, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd973, 32'd12345, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd0, 32'd5, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd1023, 32'h8000_0000, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd540, 32'd1000, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd300, 32'h8000_0000, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd300, 32'd0, 24'sd0);
      send_item(sdbq_pkg::KIND_SAMPLE, 10'd973, 32'hFFFF_FFFE, 24'sd0);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      cycle_count  = 0;
      n_loads      = 0;
      n_samples    = 0;
      n_settings   = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();
      drain();
      random_phase(130);
      hold_burst(150);
      drain();
      random_phase(130);
      drain();

      apply_config(16'd0, 10'd0, 10'd1023, 10'd0, 10'd1023);
      random_phase(220);
      drain();
      apply_config(16'hFFFF, 10'd1023, 10'd1023, 10'd5, 10'd3);
      random_phase(220);
      drain();
      apply_config(16'd1, 10'd600, 10'd200, 10'd0, 10'd409);
      random_phase(220);
      drain();
      apply_config(16'($urandom()), 10'd200, 10'd700, 10'd300, 10'd800);
      random_phase(220);
      drain();
      apply_config(16'd1000, 10'd103, 10'd512, 10'd564, 10'd973);
      random_phase(220);
      drain();

      if (sb.pending_levels.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending_levels.size()));
      $display("covered %0d loads and %0d samples over %0d register settings,",
               n_loads, n_samples, n_settings);
      $display("%0d results checked with %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("[spectrum_db_baseline_quantizer] OK");
      end else begin
         $display("[spectrum_db_baseline_quantizer] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/sdbq_pkg.sv
rtl/sdbq_front.sv
rtl/sdbq_log2.sv
rtl/sdbq_scale.sv
rtl/spectrum_db_baseline_quantizer.sv
tb/spectrum_db_baseline_quantizer_tb.sv
